// ----- sv/closure_index_relocator_assert.svh -----
// Assertion macros shared by the closure index relocator RTL.
`ifndef CLOSURE_INDEX_RELOCATOR_ASSERT_SVH
`define CLOSURE_INDEX_RELOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define CIR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("closure_index_relocator: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define CIR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("closure_index_relocator: next-cycle check failed");
`else
`define CIR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CIR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/cir_pkg.sv -----
// Shared types and constants of the closure index relocator.
package cir_pkg;

    localparam int WORD_W   = 32;
    localparam int INDEX_W  = 26;
    localparam int OPF_W    = 6;
    localparam int EXT_W    = 8;
    localparam int ERR_W    = 2;
    localparam int ADDR_W   = 2;
    localparam int EXT_SHIFT = 24;
    localparam int OP_SHIFT  = 18;
    localparam int LOW_BITS  = 12;
    localparam int HIGH_SHIFT = 20;

    // Error codes carried with every result beat.
    localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE     = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NO_PREFIX = 2'd2;

    // Configuration register indexes.
    localparam logic [ADDR_W-1:0] REG_PROTO_OFFSET   = 2'd0;
    localparam logic [ADDR_W-1:0] REG_WIDE_OPCODE    = 2'd1;
    localparam logic [ADDR_W-1:0] REG_CLOSURE_OPCODE = 2'd2;

    // Configuration register reset values.
    localparam logic [INDEX_W-1:0] PROTO_OFFSET_RST   = '0;
    localparam logic [OPF_W-1:0]   WIDE_OPCODE_RST    = 6'd0;
    localparam logic [OPF_W-1:0]   CLOSURE_OPCODE_RST = 6'd1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic [INDEX_W-1:0] proto_offset;
        logic [OPF_W-1:0]   wide_opcode;
        logic [OPF_W-1:0]   closure_opcode;
    } cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0] out_word;
        logic [ERR_W-1:0]  error_code;
        logic              run_last;
        logic              stream_end;
    } result_t;

    // Up to two result beats produced by one item, packed from slot 0.
    typedef struct packed {
        logic    v0;
        result_t r0;
        logic    v1;
        result_t r1;
    } push_t;

endpackage

// ----- sv/cir_if.sv -----
// Valid/ready channel interfaces for instruction words and results.
interface cir_instr_if;
    import cir_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] instr_word;
    logic              final_word;

    modport source (output valid, output instr_word, output final_word, input ready);
    modport sink (input valid, input instr_word, input final_word, output ready);
endinterface

interface cir_result_if;
    import cir_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] out_word;
    logic [ERR_W-1:0]  error_code;
    logic              run_last;
    logic              stream_end;

    modport source (output valid, output out_word, output error_code, output run_last,
                    output stream_end, input ready);
    modport sink (input valid, input out_word, input error_code, input run_last,
                  input stream_end, output ready);
endinterface

// ----- sv/cir_core.sv -----
// Index relocation logic and the held wide prefix state.
`include "closure_index_relocator_assert.svh"
module cir_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cir_pkg::cfg_t                   cfg,
    input  logic                            fire,
    input  logic [cir_pkg::WORD_W-1:0]      word,
    input  logic                            fin,
    output cir_pkg::push_t                  push
);
    import cir_pkg::*;

    logic              held_reg;
    logic              held_next;
    logic [WORD_W-1:0] held_word_reg;

    logic [OPF_W-1:0]   op;
    logic               is_wide;
    logic               is_clo;
    logic [OPF_W-1:0]   wb;
    logic [INDEX_W-1:0] idx;
    logic [INDEX_W:0]   sum;
    logic               ovf;
    logic [OPF_W-1:0]   hi;
    logic               miss;
    logic               rewrite;
    logic               wd_v;
    result_t            pre_res;
    result_t            wd_res;

    // Decode the opcode; a wide match wins over a closure match.
    assign op      = word[OP_SHIFT +: OPF_W];
    assign is_wide = (op == cfg.wide_opcode);
    assign is_clo  = !is_wide && (op == cfg.closure_opcode) && (cfg.proto_offset != '0);

    // Build the prototype index and add the offset.
    assign wb   = held_reg ? held_word_reg[6 +: OPF_W] : '0;
    assign idx  = {wb, word[EXT_SHIFT +: EXT_W], word[LOW_BITS-1:0]};
    assign sum  = {1'b0, idx} + {1'b0, cfg.proto_offset};
    assign ovf  = sum[INDEX_W];
    assign hi   = sum[HIGH_SHIFT +: OPF_W];
    assign miss = (hi != '0) && !held_reg;
    assign rewrite = is_clo && !ovf && !miss;

    // The held prefix leaves first, rewritten when its closure is relocated.
    always_comb
    begin
        pre_res = '0;
        if (rewrite)
        begin
            pre_res.out_word = {{EXT_W{1'b0}}, held_word_reg[23:12], hi,
                                held_word_reg[OPF_W-1:0]};
        end
        else
        begin
            pre_res.out_word = held_word_reg;
        end
        pre_res.error_code = (is_clo && ovf) ? ERR_RANGE : ERR_OK;
        pre_res.run_last   = !wd_v;
        pre_res.stream_end = 1'b0;
    end

    // The current word leaves unless it is a wide prefix that is held back.
    assign wd_v = !is_wide || fin;

    always_comb
    begin
        wd_res = '0;
        if (rewrite)
        begin
            wd_res.out_word = {sum[LOW_BITS +: EXT_W], word[23:12], sum[LOW_BITS-1:0]};
        end
        else
        begin
            wd_res.out_word = word;
        end
        if (is_clo && ovf)
        begin
            wd_res.error_code = ERR_RANGE;
        end
        else if (is_clo && miss)
        begin
            wd_res.error_code = ERR_NO_PREFIX;
        end
        else
        begin
            wd_res.error_code = ERR_OK;
        end
        wd_res.run_last   = 1'b1;
        wd_res.stream_end = fin;
    end

    // Pack the beats from slot 0.
    always_comb
    begin
        push.v0 = fire && (held_reg || wd_v);
        push.r0 = held_reg ? pre_res : wd_res;
        push.v1 = fire && held_reg && wd_v;
        push.r1 = wd_res;
    end

    // A prefix stays held only when a wide word arrives that is not the last.
    assign held_next = is_wide && !fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else if (fire)
        begin
            held_reg <= held_next;
        end
    end

    // Prefix word storage, written only by a wide word.
    always_ff @(posedge clk)
    begin
        if (fire && is_wide)
        begin
            held_word_reg <= word;
        end
    end

    `CIR_ASSERT_IMP(a_two_beats_need_prefix, clk, rst_n, push.v1, held_reg && push.v0)
    `CIR_ASSERT_NXT(a_final_clears_hold, clk, rst_n, fire && fin, !held_reg)
    `CIR_ASSERT_NXT(a_wide_sets_hold, clk, rst_n, fire && is_wide && !fin, held_reg)
endmodule

// ----- sv/cir_out_queue.sv -----
// Result queue: takes up to two beats a cycle, sends one when ready.
`include "closure_index_relocator_assert.svh"
module cir_out_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  cir_pkg::push_t   push,
    output logic             room,
    cir_result_if.source     result
);
    import cir_pkg::*;

    result_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                pop;
    logic [QPTR_W-1:0]   wr_ptr_b;

    // Two free entries are needed before an item may be processed.
    assign room = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign pop  = result.valid && result.ready;
    assign wr_ptr_b = wr_ptr_reg + QPTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.v0) + QPTR_W'(push.v1);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push.v0) + QCNT_W'(push.v1) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.v1)
        begin
            mem_reg[wr_ptr_b] <= push.r1;
        end
    end

    // Head of the queue drives the result channel.
    assign result.valid      = (count_reg != '0);
    assign result.out_word   = mem_reg[rd_ptr_reg].out_word;
    assign result.error_code = mem_reg[rd_ptr_reg].error_code;
    assign result.run_last   = mem_reg[rd_ptr_reg].run_last;
    assign result.stream_end = mem_reg[rd_ptr_reg].stream_end;

    `CIR_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH))
    `CIR_ASSERT_IMP(a_push_has_room, clk, rst_n, push.v0, room)
    `CIR_ASSERT_IMP(a_slot1_after_slot0, clk, rst_n, push.v1, push.v0)
endmodule

// ----- sv/closure_index_relocator.sv -----
// Top level of the closure index relocator.
//
//   channel   direction  beat contents
//   instr     in         instr_word, final_word
//   result    out        out_word, error_code, run_last, stream_end
//   cfg       in         cfg_en, cfg_addr, cfg_data (write only)
//
// One instruction word is accepted per cycle unless the result queue stalls input;
// each word yields zero, one or two result beats, and the result port sends one
// beat per cycle while result.ready is high. An accepted word waits in the input
// register, then its beats enter the result queue, which drives the result port.
// The four-entry result queue sets the stall: a word is processed only when two
// entries are free, so two-beat words stall input while the result side drains.
// Reset clears the held prefix and the queue and returns the configuration
// registers to their default values.
module closure_index_relocator (
    input  logic                            clk,
    input  logic                            rst_n,
    cir_instr_if.sink                       instr,
    cir_result_if.source                    result,
    input  logic                            cfg_en,
    input  logic [cir_pkg::ADDR_W-1:0]      cfg_addr,
    input  logic [cir_pkg::INDEX_W-1:0]     cfg_data
);
    import cir_pkg::*;

    cfg_t              cfg_reg;
    logic              s1_valid_reg;
    logic [WORD_W-1:0] s1_word_reg;
    logic              s1_fin_reg;
    logic              fire;
    logic              room;
    push_t             push;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.proto_offset   <= PROTO_OFFSET_RST;
            cfg_reg.wide_opcode    <= WIDE_OPCODE_RST;
            cfg_reg.closure_opcode <= CLOSURE_OPCODE_RST;
        end
        else if (cfg_en)
        begin
            case (cfg_addr)
                REG_PROTO_OFFSET:   cfg_reg.proto_offset   <= cfg_data;
                REG_WIDE_OPCODE:    cfg_reg.wide_opcode    <= cfg_data[OPF_W-1:0];
                REG_CLOSURE_OPCODE: cfg_reg.closure_opcode <= cfg_data[OPF_W-1:0];
                default:            ;
            endcase
        end
    end

    // Input register; it refills in the cycle its word is processed.
    assign fire = s1_valid_reg && room;
    assign instr.ready = !s1_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (instr.ready)
        begin
            s1_valid_reg <= instr.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (instr.valid && instr.ready)
        begin
            s1_word_reg <= instr.instr_word;
            s1_fin_reg  <= instr.final_word;
        end
    end

    cir_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .fire  (fire),
        .word  (s1_word_reg),
        .fin   (s1_fin_reg),
        .push  (push)
    );

    cir_out_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .result (result)
    );
endmodule

// ----- test/closure_index_relocator_tb.sv -----
// Self-checking testbench for the closure index relocator: directed table, then random streams.
`timescale 1ns / 100ps

module closure_index_relocator_tb;
    import cir_pkg::*;

    localparam logic [INDEX_W-1:0] OFFSET_MAX = '1;
    localparam int SETTLE_CYCLES = 8;
    localparam int RAND_PHASES = 7;
    localparam int PHASE_WORDS = 150;

    // One row of the directed table: setting to run under, the word, and an
    // optional typed expectation for the beat that carries the word.
    typedef struct packed {
        logic [1:0]        setting;
        logic [WORD_W-1:0] word;
        logic              fin;
        logic              typed;
        logic [WORD_W-1:0] exp_word;
        logic [ERR_W-1:0]  exp_err;
    } row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_en;
    logic [ADDR_W-1:0] cfg_addr;
    logic [INDEX_W-1:0] cfg_data;

    cir_instr_if instr_ch ();
    cir_result_if result_ch ();

    closure_index_relocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .instr    (instr_ch),
        .result   (result_ch),
        .cfg_en   (cfg_en),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    // Predictor copy of the configuration and of the held prefix.
    logic [INDEX_W-1:0] offset_cfg = PROTO_OFFSET_RST;
    logic [OPF_W-1:0]   wide_op_cfg = WIDE_OPCODE_RST;
    logic [OPF_W-1:0]   closure_op_cfg = CLOSURE_OPCODE_RST;
    logic               prefix_waiting = 1'b0;
    logic [WORD_W-1:0]  waiting_prefix = '0;

    result_t relocated_beats [$];
    row_t    dir_rows [$];
    int      mismatch_count = 0;
    bit      calm = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < 50)
            $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic result_t plain_beat(input logic [WORD_W-1:0] w,
                                           input logic [ERR_W-1:0] err);
        result_t b;
        b.out_word   = w;
        b.error_code = err;
        b.run_last   = 1'b0;
        b.stream_end = 1'b0;
        return b;
    endfunction

    // Works out the beats that one accepted word causes and queues them.
    task automatic relocate_word(input logic [WORD_W-1:0] w, input logic fin,
                                 input logic typed, input logic [WORD_W-1:0] typed_word,
                                 input logic [ERR_W-1:0] typed_err);
        result_t            beats [2];
        int                 n;
        int                 word_pos;
        int                 i;
        logic [OPF_W-1:0]   op;
        logic [OPF_W-1:0]   wide_b;
        logic [INDEX_W-1:0] index;
        logic [INDEX_W:0]   moved;
        n = 0;
        word_pos = -1;
        op = w[23:18];
        if (op == wide_op_cfg)
        begin
            // A new prefix pushes out any prefix still held.
            if (prefix_waiting)
            begin
                beats[n] = plain_beat(waiting_prefix, ERR_OK);
                n++;
            end
            prefix_waiting = 1'b1;
            waiting_prefix = w;
            if (fin)
            begin
                word_pos = n;
                beats[n] = plain_beat(w, ERR_OK);
                n++;
                prefix_waiting = 1'b0;
            end
        end
        else if (op == closure_op_cfg && offset_cfg != '0)
        begin
            wide_b = prefix_waiting ? waiting_prefix[11:6] : '0;
            index = {wide_b, w[31:24], w[11:0]};
            moved = {1'b0, index} + {1'b0, offset_cfg};
            if (moved[INDEX_W])
            begin
                // Index overflow: prefix and closure pass unchanged, both flagged.
                if (prefix_waiting)
                begin
                    beats[n] = plain_beat(waiting_prefix, ERR_RANGE);
                    n++;
                end
                word_pos = n;
                beats[n] = plain_beat(w, ERR_RANGE);
                n++;
            end
            else if (moved[25:20] != '0 && !prefix_waiting)
            begin
                word_pos = n;
                beats[n] = plain_beat(w, ERR_NO_PREFIX);
                n++;
            end
            else
            begin
                // High index bits go to the prefix, the rest to ext and b:c.
                if (prefix_waiting)
                begin
                    beats[n] = plain_beat({8'h00, waiting_prefix[23:12], moved[25:20],
                                           waiting_prefix[5:0]}, ERR_OK);
                    n++;
                end
                word_pos = n;
                beats[n] = plain_beat({moved[19:12], w[23:12], moved[11:0]}, ERR_OK);
                n++;
            end
            prefix_waiting = 1'b0;
        end
        else
        begin
            if (prefix_waiting)
            begin
                beats[n] = plain_beat(waiting_prefix, ERR_OK);
                n++;
            end
            prefix_waiting = 1'b0;
            word_pos = n;
            beats[n] = plain_beat(w, ERR_OK);
            n++;
        end

        if (word_pos >= 0)
        begin
            beats[word_pos].stream_end = fin;
            if (typed)
            begin
                beats[word_pos].out_word   = typed_word;
                beats[word_pos].error_code = typed_err;
            end
        end
        if (n > 0)
            beats[n-1].run_last = 1'b1;
        for (i = 0; i < n; i++)
            relocated_beats = {relocated_beats, beats[i]};
    endtask

    // Offers one word, with an occasional idle burst first, and waits for it to be taken.
    task automatic send_word(input logic [WORD_W-1:0] w, input logic fin, input logic typed,
                             input logic [WORD_W-1:0] typed_word,
                             input logic [ERR_W-1:0] typed_err);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            instr_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        instr_ch.valid      <= 1'b1;
        instr_ch.instr_word <= w;
        instr_ch.final_word <= fin;
        @(posedge clk);
        while (!instr_ch.ready)
            @(posedge clk);
        relocate_word(w, fin, typed, typed_word, typed_err);
    endtask

    task automatic send_random(input logic [WORD_W-1:0] w);
        send_word(w, $urandom_range(0, 19) == 0, 1'b0, '0, ERR_OK);
    endtask

    // Stops the sender until every queued beat is back, then lets the pipeline settle.
    task automatic wait_quiet();
        instr_ch.valid <= 1'b0;
        while (relocated_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [INDEX_W-1:0] value);
        cfg_en   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [INDEX_W-1:0] off, input logic [OPF_W-1:0] wop,
                              input logic [OPF_W-1:0] cop);
        write_reg(REG_PROTO_OFFSET, off);
        write_reg(REG_WIDE_OPCODE, INDEX_W'(wop));
        write_reg(REG_CLOSURE_OPCODE, INDEX_W'(cop));
        cfg_en <= 1'b0;
        offset_cfg = off;
        wide_op_cfg = wop;
        closure_op_cfg = cop;
    endtask

    // Settings used by the directed table; setting 0 is the reset state, run first without being applied.
    task automatic apply_setting(input logic [1:0] s);
        case (s)
            2'd1: set_config(26'd1, 6'd63, 6'd0);
            2'd2: set_config(OFFSET_MAX, 6'd0, 6'd63);
            default: set_config(26'd5, 6'd7, 6'd7);
        endcase
    endtask

    function automatic logic [WORD_W-1:0] with_op(input logic [OPF_W-1:0] op);
        logic [WORD_W-1:0] w;
        w = $urandom;
        w[23:18] = op;
        return w;
    endfunction

    task automatic add_row(input logic [1:0] s, input logic [WORD_W-1:0] w, input logic fin,
                           input logic typed, input logic [WORD_W-1:0] exp_word,
                           input logic [ERR_W-1:0] exp_err);
        row_t r;
        r.setting  = s;
        r.word     = w;
        r.fin      = fin;
        r.typed    = typed;
        r.exp_word = exp_word;
        r.exp_err  = exp_err;
        dir_rows = {dir_rows, r};
    endtask

    // Every accepted result beat is compared with the oldest expectation.
    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (relocated_beats.size() == 0)
                report_mismatch($sformatf("unexpected beat %h", result_ch.out_word));
            else
            begin
                want = relocated_beats.pop_front();
                if (result_ch.out_word !== want.out_word)
                    report_mismatch($sformatf("out_word %h, want %h",
                                              result_ch.out_word, want.out_word));
                if (result_ch.error_code !== want.error_code)
                    report_mismatch($sformatf("error_code %0d, want %0d on word %h",
                                              result_ch.error_code, want.error_code,
                                              want.out_word));
                if (result_ch.run_last !== want.run_last)
                    report_mismatch($sformatf("run_last %b, want %b on word %h",
                                              result_ch.run_last, want.run_last,
                                              want.out_word));
                if (result_ch.stream_end !== want.stream_end)
                    report_mismatch($sformatf("stream_end %b, want %b on word %h",
                                              result_ch.stream_end, want.stream_end,
                                              want.out_word));
            end
        end
    end

    // Result side stalls in random bursts until the calm stretch at the end.
    initial
    begin
        result_ch.ready = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("[closure_index_relocator] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        row_t             r;
        logic [1:0]       cur_setting;
        int               phase;
        int               sent;
        int               kind;
        bit               paused;
        logic [INDEX_W-1:0] off;
        logic [OPF_W-1:0] wop;
        logic [OPF_W-1:0] cop;

        rst_n = 1'b0;
        cfg_en = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        instr_ch.valid = 1'b0;
        instr_ch.instr_word = '0;
        instr_ch.final_word = 1'b0;

        // Reset values: zero offset, so closures pass unchanged.
        add_row(0, {8'h12, 6'd1, 6'd5, 6'd6, 6'd7}, 0, 1, {8'h12, 6'd1, 6'd5, 6'd6, 6'd7},
                ERR_OK);
        add_row(0, {8'hff, 6'd0, 6'd63, 6'd63, 6'd63}, 0, 0, '0, ERR_OK);
        add_row(0, {8'h00, 6'd1, 6'd0, 6'd0, 6'd0}, 0, 1, {8'h00, 6'd1, 6'd0, 6'd0, 6'd0},
                ERR_OK);
        // Offset one, wide opcode 63, closure opcode 0.
        add_row(1, {8'h00, 6'd0, 6'd63, 6'd0, 6'd0}, 0, 1, {8'h00, 6'd0, 6'd63, 12'h001},
                ERR_OK);
        add_row(1, {8'hff, 6'd0, 6'd0, 6'd63, 6'd63}, 0, 1, {8'hff, 6'd0, 6'd0, 6'd63, 6'd63},
                ERR_NO_PREFIX);
        add_row(1, {8'h00, 6'd63, 6'd0, 6'd0, 6'd0}, 0, 0, '0, ERR_OK);
        add_row(1, {8'hff, 6'd0, 6'd0, 6'd63, 6'd63}, 0, 0, '0, ERR_OK);
        add_row(1, 32'hffff_ffff, 0, 0, '0, ERR_OK);
        add_row(1, {8'hff, 6'd0, 6'd63, 6'd63, 6'd63}, 0, 1, {8'hff, 6'd0, 6'd63, 6'd63, 6'd63},
                ERR_RANGE);
        // Wide after wide, then a prefix before a plain word.
        add_row(1, {8'h5a, 6'd63, 6'd1, 6'd2, 6'd3}, 0, 0, '0, ERR_OK);
        add_row(1, {8'ha5, 6'd63, 6'd4, 6'd5, 6'd6}, 0, 0, '0, ERR_OK);
        add_row(1, {8'h00, 6'd9, 6'd10, 6'd11, 6'd12}, 0, 1, {8'h00, 6'd9, 6'd10, 6'd11, 6'd12},
                ERR_OK);
        // Final word as a lone prefix, as a plain word, and as a relocated closure.
        add_row(1, {8'h3c, 6'd63, 6'd21, 6'd22, 6'd23}, 1, 1,
                {8'h3c, 6'd63, 6'd21, 6'd22, 6'd23}, ERR_OK);
        add_row(1, {8'hc3, 6'd20, 6'd30, 6'd31, 6'd32}, 1, 1,
                {8'hc3, 6'd20, 6'd30, 6'd31, 6'd32}, ERR_OK);
        add_row(1, {8'h00, 6'd63, 6'd0, 6'd2, 6'd0}, 0, 0, '0, ERR_OK);
        add_row(1, {8'h80, 6'd0, 6'd33, 6'd17, 6'd40}, 1, 0, '0, ERR_OK);
        // Largest offset, wide opcode 0, closure opcode 63.
        add_row(2, {8'h00, 6'd63, 6'd10, 6'd0, 6'd0}, 0, 1, {8'h00, 6'd63, 6'd10, 6'd0, 6'd0},
                ERR_NO_PREFIX);
        add_row(2, {8'h77, 6'd0, 6'd0, 6'd0, 6'd0}, 0, 0, '0, ERR_OK);
        add_row(2, {8'h00, 6'd63, 6'd0, 6'd0, 6'd0}, 0, 0, '0, ERR_OK);
        add_row(2, 32'h0000_0000, 0, 0, '0, ERR_OK);
        add_row(2, {8'h00, 6'd63, 6'd0, 6'd0, 6'd1}, 0, 1, {8'h00, 6'd63, 6'd0, 6'd0, 6'd1},
                ERR_RANGE);
        // Equal opcodes: the word counts as a prefix.
        add_row(3, {8'h01, 6'd7, 6'd0, 6'd0, 6'd0}, 0, 0, '0, ERR_OK);
        add_row(3, {8'h02, 6'd7, 6'd1, 6'd1, 6'd1}, 0, 0, '0, ERR_OK);
        add_row(3, {8'h03, 6'd8, 6'd2, 6'd2, 6'd2}, 1, 1, {8'h03, 6'd8, 6'd2, 6'd2, 6'd2},
                ERR_OK);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, reconfiguring whenever the setting changes.
        cur_setting = 2'd0;
        foreach (dir_rows[k])
        begin
            r = dir_rows[k];
            if (r.setting != cur_setting)
            begin
                wait_quiet();
                apply_setting(r.setting);
                cur_setting = r.setting;
            end
            send_word(r.word, r.fin, r.typed, r.exp_word, r.exp_err);
        end

        // Random phases, each under a fresh configuration.
        paused = 1'b0;
        for (phase = 0; phase < RAND_PHASES; phase++)
        begin
            wait_quiet();
            case ($urandom_range(0, 5))
                0: off = '0;
                1: off = OFFSET_MAX;
                2: off = INDEX_W'($urandom_range(1, 255));
                3: off = INDEX_W'($urandom_range(26'h3f00000, 26'h3ffffff));
                default: off = INDEX_W'($urandom);
            endcase
            wop = OPF_W'($urandom_range(0, 63));
            cop = ($urandom_range(0, 5) == 0) ? wop : 6'($urandom_range(0, 63));
            set_config(off, wop, cop);
            if (phase == RAND_PHASES - 1)
                calm = 1'b1;

            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                // Once in the run the sender holds off until everything is back.
                if (phase == 3 && sent >= PHASE_WORDS / 2 && !paused)
                begin
                    wait_quiet();
                    paused = 1'b1;
                end
                kind = $urandom_range(0, 99);
                if (kind < 35)
                begin
                    // Closure, usually behind its wide prefix.
                    if ($urandom_range(0, 9) < 6)
                    begin
                        send_random(with_op(wop));
                        sent++;
                    end
                    send_random(with_op(cop));
                    sent++;
                end
                else if (kind < 45)
                begin
                    // Broken sequence: prefix followed by an arbitrary word.
                    send_random(with_op(wop));
                    send_random(with_op(OPF_W'($urandom_range(0, 63))));
                    sent += 2;
                end
                else if (kind < 85)
                begin
                    send_random(with_op(OPF_W'($urandom_range(0, 63))));
                    sent++;
                end
                else
                begin
                    send_random($urandom);
                    sent++;
                end
            end
        end

        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[closure_index_relocator] OK");
        else
            $display("[closure_index_relocator] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/cir_pkg.sv
sv/cir_if.sv
sv/cir_core.sv
sv/cir_out_queue.sv
sv/closure_index_relocator.sv
test/closure_index_relocator_tb.sv
